@@ hdl/twodo_pkg.sv @@
// twodo_pkg: constants, state and job types, angle and series tables for the
// three-wheel odometry block
// no dependencies
package twodo_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned DIV_STEPS    = 81;
  localparam int unsigned WIDE_W       = 60;

  localparam logic [6:0]  DIV_LAST    = 7'(DIV_STEPS - 1);
  localparam logic [4:0]  CORDIC_LAST = 5'(CORDIC_STEPS - 1);

  localparam logic [32:0] TURN_LIMIT   = 33'h1_FFFF_FFFF;
  localparam logic [29:0] RAD_TO_BAM   = 30'd683565276;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

  localparam logic [23:0] TICK_RST  = 24'd402624;
  localparam logic [23:0] LEFT_RST  = 24'd352256;
  localparam logic [23:0] RIGHT_RST = 24'd352256;
  localparam logic [23:0] BACK_RST  = 24'd397312;

  typedef enum logic [1:0] {
    REG_TICK  = 2'd0,
    REG_LEFT  = 2'd1,
    REG_RIGHT = 2'd2,
    REG_BACK  = 2'd3
  } reg_addr_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LD, ST_RD, ST_BD, ST_DIFF, ST_DIVSET, ST_DIV, ST_TSET,
    ST_HEAD, ST_HUPD, ST_USQ, ST_SW, ST_SQ, ST_SR, ST_SP, ST_OFFB, ST_OFFR,
    ST_SXY, ST_CSET, ST_CORD, ST_CFIN, ST_MHI, ST_MLO, ST_MSGN, ST_DX, ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    JOB_XL, JOB_YL, JOB_XC, JOB_YS, JOB_YC, JOB_XS
  } job_e;

  function automatic logic [29:0] atan_bam(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // series denominators 2n(2n+1)
  function automatic logic [7:0] sinc_den(input logic [2:0] n);
    logic [7:0] v;
    case (n)
      3'd7: v = 8'd210;
      3'd6: v = 8'd156;
      3'd5: v = 8'd110;
      3'd4: v = 8'd72;
      3'd3: v = 8'd42;
      3'd2: v = 8'd20;
      3'd1: v = 8'd6;
      default: v = 8'd1;
    endcase
    return v;
  endfunction

  // floor(2^32 / denominator)
  function automatic logic [29:0] sinc_recip(input logic [2:0] n);
    logic [29:0] v;
    case (n)
      3'd7: v = 30'd20452225;
      3'd6: v = 30'd27531841;
      3'd5: v = 30'd39045157;
      3'd4: v = 30'd59652323;
      3'd3: v = 30'd102261126;
      3'd2: v = 30'd214748364;
      3'd1: v = 30'd715827882;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/tracking_wheel_odometry.sv @@
// tracking_wheel_odometry: three tracking wheel odometry with one shared
// multiplier, a restoring divider and a cordic under a sequencer
// depends on twodo_pkg
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid_i, in_ready_o, *_count_i         | in
//   result  | out_valid_o, out_ready_i, pos_x/y_o, heading_o | out
//   config  | psel, penable, pwrite, paddr, pwdata, prdata, pready | apb
//
// a transaction runs 81 divider steps (skipped when the left and right offsets
// sum to zero), the sinc series on the shared multiplier, CORDIC_STEPS cordic
// rotations and the rotation products
// in_ready_o is high only while the sequencer is idle
// a finished result waits in the output registers; the next transaction is
// taken meanwhile and stalls only at its final commit
// reset loads the register defaults and clears position, heading and counts
module tracking_wheel_odometry (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  left_count_i,
  input  logic signed [31:0]  right_count_i,
  input  logic signed [31:0]  back_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [47:0]  pos_x_o,
  output logic signed [47:0]  pos_y_o,
  output logic [31:0]         heading_o
);

  localparam int unsigned W = twodo_pkg::WIDE_W;

  twodo_pkg::state_e state_q, state_d;
  twodo_pkg::job_e   job_q;

  logic [23:0] tick_q, loff_q, roff_q, boff_q;
  logic [31:0] last_l_q, last_r_q, last_b_q, heading_q;
  logic signed [47:0] x_acc_q, y_acc_q;
  logic out_valid_q;
  logic [6:0] cnt_q;
  logic [4:0] ci_q;
  logic [2:0] n_q;

  logic signed [31:0] dl_q, dr_q, db_q;
  logic signed [56:0] ld_q, rd_q, bd_q;
  logic signed [57:0] diff_q;
  logic [56:0] num_q;
  logic [24:0] rem_q;
  logic [32:0] quo_q, tmag_q;
  logic sat_q, neg_q;
  logic [30:0] bm_q;
  logic [31:0] head_new_q, mid_q;
  logic [29:0] u_q, w_q, r_q;
  logic [30:0] p_q;
  logic [27:0] q0_q;
  logic signed [33:0] tb_q, tr_q;
  logic signed [W-1:0] sx_q, sy_q;
  logic signed [33:0] cx_q, cy_q, cz_q, c_q, s_q;
  logic flip_q;
  logic [57:0] hi_q, mres_q;
  logic signed [W-1:0] xl_q, yl_q, pxc_q, pys_q, pyc_q, pxs_q, dx_q, dy_q;

  logic accept;
  logic cfg_wr;
  twodo_pkg::reg_addr_e cfg_addr;
  logic commit;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == twodo_pkg::ST_IDLE);
  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_addr   = twodo_pkg::reg_addr_e'(paddr[3:2]);
  assign pready     = 1'b1;
  assign commit     = (state_q == twodo_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    unique case (cfg_addr)
      twodo_pkg::REG_TICK:  prdata = {8'd0, tick_q};
      twodo_pkg::REG_LEFT:  prdata = {8'd0, loff_q};
      twodo_pkg::REG_RIGHT: prdata = {8'd0, roff_q};
      twodo_pkg::REG_BACK:  prdata = {8'd0, boff_q};
      default:              prdata = '0;
    endcase
  end

  // magnitudes and sign helpers
  logic [31:0] dl_mag, dr_mag, db_mag, hm;
  logic [24:0] span;
  logic [59:0] diff_mag;
  logic signed [W-1:0] a_sel;
  logic signed [33:0] k_sel;
  logic [W-1:0] a_mag;
  logic [33:0] k_mag;
  logic [7:0] den;
  logic [29:0] recip;

  assign dl_mag   = dl_q[31] ? 32'(-dl_q) : 32'(dl_q);
  assign dr_mag   = dr_q[31] ? 32'(-dr_q) : 32'(dr_q);
  assign db_mag   = db_q[31] ? 32'(-db_q) : 32'(db_q);
  assign hm       = tmag_q[32:1];
  assign span     = {1'b0, loff_q} + {1'b0, roff_q};
  assign diff_mag = diff_q[57] ? 60'(-diff_q) : 60'(diff_q);
  assign den      = twodo_pkg::sinc_den(n_q);
  assign recip    = twodo_pkg::sinc_recip(n_q);

  always_comb begin
    unique case (job_q)
      twodo_pkg::JOB_XL: begin a_sel = sx_q; k_sel = 34'($signed({3'd0, p_q})); end
      twodo_pkg::JOB_YL: begin a_sel = sy_q; k_sel = 34'($signed({3'd0, p_q})); end
      twodo_pkg::JOB_XC: begin a_sel = xl_q; k_sel = c_q; end
      twodo_pkg::JOB_YS: begin a_sel = yl_q; k_sel = s_q; end
      twodo_pkg::JOB_YC: begin a_sel = yl_q; k_sel = c_q; end
      default:           begin a_sel = xl_q; k_sel = s_q; end
    endcase
  end

  assign a_mag = a_sel[W-1] ? W'(-a_sel) : W'(a_sel);
  assign k_mag = k_sel[33] ? 34'(-k_sel) : 34'(k_sel);

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      twodo_pkg::ST_LD:   begin mul_a = {1'b0, dl_mag}; mul_b = {8'd0, tick_q}; end
      twodo_pkg::ST_RD:   begin mul_a = {1'b0, dr_mag}; mul_b = {8'd0, tick_q}; end
      twodo_pkg::ST_BD:   begin mul_a = {1'b0, db_mag}; mul_b = {8'd0, tick_q}; end
      twodo_pkg::ST_HEAD: begin mul_a = tmag_q; mul_b = {2'd0, twodo_pkg::RAD_TO_BAM}; end
      twodo_pkg::ST_USQ:  begin mul_a = {1'b0, hm}; mul_b = hm; end
      twodo_pkg::ST_SW:   begin mul_a = {3'd0, u_q}; mul_b = {1'b0, p_q}; end
      twodo_pkg::ST_SQ:   begin mul_a = {3'd0, w_q}; mul_b = {2'd0, recip}; end
      twodo_pkg::ST_SR:   begin mul_a = {5'd0, q0_q}; mul_b = {24'd0, den}; end
      twodo_pkg::ST_OFFB: begin mul_a = tmag_q; mul_b = {8'd0, boff_q}; end
      twodo_pkg::ST_OFFR: begin mul_a = tmag_q; mul_b = {8'd0, roff_q}; end
      twodo_pkg::ST_MHI:  begin mul_a = {6'd0, a_mag[56:30]}; mul_b = k_mag[31:0]; end
      twodo_pkg::ST_MLO:  begin mul_a = {3'd0, a_mag[29:0]}; mul_b = k_mag[31:0]; end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      twodo_pkg::ST_IDLE:   if (in_valid_i) state_d = twodo_pkg::ST_LD;
      twodo_pkg::ST_LD:     state_d = twodo_pkg::ST_RD;
      twodo_pkg::ST_RD:     state_d = twodo_pkg::ST_BD;
      twodo_pkg::ST_BD:     state_d = twodo_pkg::ST_DIFF;
      twodo_pkg::ST_DIFF:   state_d = twodo_pkg::ST_DIVSET;
      twodo_pkg::ST_DIVSET: state_d = (span == '0) ? twodo_pkg::ST_TSET : twodo_pkg::ST_DIV;
      twodo_pkg::ST_DIV:    if (cnt_q == twodo_pkg::DIV_LAST) state_d = twodo_pkg::ST_TSET;
      twodo_pkg::ST_TSET:   state_d = twodo_pkg::ST_HEAD;
      twodo_pkg::ST_HEAD:   state_d = twodo_pkg::ST_HUPD;
      twodo_pkg::ST_HUPD:   state_d = twodo_pkg::ST_USQ;
      twodo_pkg::ST_USQ:    state_d = twodo_pkg::ST_SW;
      twodo_pkg::ST_SW:     state_d = twodo_pkg::ST_SQ;
      twodo_pkg::ST_SQ:     state_d = twodo_pkg::ST_SR;
      twodo_pkg::ST_SR:     state_d = twodo_pkg::ST_SP;
      twodo_pkg::ST_SP:     state_d = (n_q == 3'd1) ? twodo_pkg::ST_OFFB : twodo_pkg::ST_SW;
      twodo_pkg::ST_OFFB:   state_d = twodo_pkg::ST_OFFR;
      twodo_pkg::ST_OFFR:   state_d = twodo_pkg::ST_SXY;
      twodo_pkg::ST_SXY:    state_d = twodo_pkg::ST_CSET;
      twodo_pkg::ST_CSET:   state_d = twodo_pkg::ST_CORD;
      twodo_pkg::ST_CORD:   if (ci_q == twodo_pkg::CORDIC_LAST) state_d = twodo_pkg::ST_CFIN;
      twodo_pkg::ST_CFIN:   state_d = twodo_pkg::ST_MHI;
      twodo_pkg::ST_MHI:    state_d = twodo_pkg::ST_MLO;
      twodo_pkg::ST_MLO:    state_d = twodo_pkg::ST_MSGN;
      twodo_pkg::ST_MSGN:   state_d = (job_q == twodo_pkg::JOB_XS) ? twodo_pkg::ST_DX
                                                                   : twodo_pkg::ST_MHI;
      twodo_pkg::ST_DX:     state_d = twodo_pkg::ST_OUT;
      twodo_pkg::ST_OUT:    if (commit) state_d = twodo_pkg::ST_IDLE;
      default:              state_d = twodo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twodo_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // position update with saturation
  logic signed [52:0] x_sum, y_sum;
  logic signed [47:0] x_sat, y_sat;

  assign x_sum = 53'(x_acc_q) + 53'(dx_q >>> 8);
  assign y_sum = 53'(y_acc_q) + 53'(dy_q >>> 8);
  assign x_sat = (x_sum[52:47] == {6{x_sum[52]}}) ? x_sum[47:0]
               : (x_sum[52] ? twodo_pkg::POS_MIN : twodo_pkg::POS_MAX);
  assign y_sat = (y_sum[52:47] == {6{y_sum[52]}}) ? y_sum[47:0]
               : (y_sum[52] ? twodo_pkg::POS_MIN : twodo_pkg::POS_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= twodo_pkg::TICK_RST;
      loff_q      <= twodo_pkg::LEFT_RST;
      roff_q      <= twodo_pkg::RIGHT_RST;
      boff_q      <= twodo_pkg::BACK_RST;
      last_l_q    <= '0;
      last_r_q    <= '0;
      last_b_q    <= '0;
      heading_q   <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ci_q        <= '0;
      n_q         <= '0;
      job_q       <= twodo_pkg::JOB_XL;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_addr)
          twodo_pkg::REG_TICK:  tick_q <= pwdata[23:0];
          twodo_pkg::REG_LEFT:  loff_q <= pwdata[23:0];
          twodo_pkg::REG_RIGHT: roff_q <= pwdata[23:0];
          twodo_pkg::REG_BACK:  boff_q <= pwdata[23:0];
          default: ;
        endcase
      end
      if (accept) begin
        last_l_q <= left_count_i;
        last_r_q <= right_count_i;
        last_b_q <= back_count_i;
      end
      if (commit) begin
        heading_q   <= head_new_q;
        x_acc_q     <= x_sat;
        y_acc_q     <= y_sat;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        twodo_pkg::ST_DIVSET: cnt_q <= '0;
        twodo_pkg::ST_DIV:    cnt_q <= cnt_q + 7'd1;
        twodo_pkg::ST_USQ:    n_q <= 3'd7;
        twodo_pkg::ST_SP:     n_q <= n_q - 3'd1;
        twodo_pkg::ST_CSET:   ci_q <= '0;
        twodo_pkg::ST_CORD:   ci_q <= ci_q + 5'd1;
        twodo_pkg::ST_CFIN:   job_q <= twodo_pkg::JOB_XL;
        twodo_pkg::ST_MSGN:   job_q <= twodo_pkg::job_e'(job_q + 3'd1);
        default: ;
      endcase
    end
  end

  // datapath
  logic [25:0] r2;
  logic        ge;
  logic [31:0] b32, half32;
  logic [28:0] qf;
  logic [57:0] offp;
  logic signed [57:0] offs;
  logic [31:0] cang;
  logic signed [33:0] xsh, ysh, atan_s;
  logic signed [W-1:0] mres_s;

  assign r2     = {rem_q, num_q[56]};
  assign ge     = r2 >= {1'b0, span};
  assign b32    = neg_q ? 32'(-{1'b0, bm_q}) : {1'b0, bm_q};
  assign half32 = neg_q ? 32'(-{2'b0, bm_q[30:1]}) : {2'b0, bm_q[30:1]};
  assign qf     = {1'b0, q0_q} + ((r_q >= {22'd0, den}) ? 29'd1 : 29'd0);
  assign offp   = {1'b0, mul_p[56:0]};
  assign offs   = neg_q ? -$signed(offp) : $signed(offp);
  assign cang   = mid_q + 32'h4000_0000;
  assign xsh    = cx_q >>> ci_q;
  assign ysh    = cy_q >>> ci_q;
  assign atan_s = $signed({4'd0, twodo_pkg::atan_bam(ci_q)});
  assign mres_s = ((a_sel[W-1]) != (k_sel[33])) ? -$signed({2'b0, mres_q})
                                                 : $signed({2'b0, mres_q});

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      twodo_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          dl_q <= left_count_i - last_l_q;
          dr_q <= right_count_i - last_r_q;
          db_q <= back_count_i - last_b_q;
        end
      end
      twodo_pkg::ST_LD: ld_q <= dl_q[31] ? -$signed({2'b0, mul_p[54:0]})
                                         : $signed({2'b0, mul_p[54:0]});
      twodo_pkg::ST_RD: rd_q <= dr_q[31] ? -$signed({2'b0, mul_p[54:0]})
                                         : $signed({2'b0, mul_p[54:0]});
      twodo_pkg::ST_BD: bd_q <= db_q[31] ? -$signed({2'b0, mul_p[54:0]})
                                         : $signed({2'b0, mul_p[54:0]});
      twodo_pkg::ST_DIFF: diff_q <= 58'(ld_q) - 58'(rd_q);
      twodo_pkg::ST_DIVSET: begin
        num_q <= diff_mag[56:0];
        neg_q <= diff_q[57];
        rem_q <= '0;
        quo_q <= '0;
        sat_q <= 1'b0;
      end
      twodo_pkg::ST_DIV: begin
        num_q <= {num_q[55:0], 1'b0};
        rem_q <= ge ? 25'(r2 - {1'b0, span}) : r2[24:0];
        quo_q <= {quo_q[31:0], ge};
        sat_q <= sat_q | quo_q[32];
      end
      twodo_pkg::ST_TSET: tmag_q <= sat_q ? twodo_pkg::TURN_LIMIT : quo_q;
      twodo_pkg::ST_HEAD: bm_q <= mul_p[62:32];
      twodo_pkg::ST_HUPD: begin
        head_new_q <= heading_q + b32;
        mid_q      <= heading_q + b32 - half32;
      end
      twodo_pkg::ST_USQ: begin
        u_q <= mul_p[63:34];
        p_q <= twodo_pkg::ONE_Q30;
      end
      twodo_pkg::ST_SW: w_q  <= mul_p[59:30];
      twodo_pkg::ST_SQ: q0_q <= mul_p[59:32];
      twodo_pkg::ST_SR: r_q  <= w_q - mul_p[29:0];
      twodo_pkg::ST_SP: p_q  <= twodo_pkg::ONE_Q30 - {2'b0, qf};
      twodo_pkg::ST_OFFB: tb_q <= offs[57:24];
      twodo_pkg::ST_OFFR: tr_q <= offs[57:24];
      twodo_pkg::ST_SXY: begin
        sx_q <= W'(bd_q) + W'(tb_q);
        sy_q <= W'(rd_q) + W'(tr_q);
      end
      twodo_pkg::ST_CSET: begin
        flip_q <= cang[31];
        cz_q   <= 34'($signed(mid_q ^ {cang[31], 31'd0}));
        cx_q   <= twodo_pkg::CORDIC_START;
        cy_q   <= '0;
      end
      twodo_pkg::ST_CORD: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ysh;
          cy_q <= cy_q + xsh;
          cz_q <= cz_q - atan_s;
        end else begin
          cx_q <= cx_q + ysh;
          cy_q <= cy_q - xsh;
          cz_q <= cz_q + atan_s;
        end
      end
      twodo_pkg::ST_CFIN: begin
        c_q <= flip_q ? -cx_q : cx_q;
        s_q <= flip_q ? -cy_q : cy_q;
      end
      twodo_pkg::ST_MHI: hi_q <= mul_p[57:0];
      twodo_pkg::ST_MLO: mres_q <= hi_q + {26'd0, mul_p[61:30]};
      twodo_pkg::ST_MSGN: begin
        unique case (job_q)
          twodo_pkg::JOB_XL: xl_q  <= mres_s;
          twodo_pkg::JOB_YL: yl_q  <= mres_s;
          twodo_pkg::JOB_XC: pxc_q <= mres_s;
          twodo_pkg::JOB_YS: pys_q <= mres_s;
          twodo_pkg::JOB_YC: pyc_q <= mres_s;
          default:           pxs_q <= mres_s;
        endcase
      end
      twodo_pkg::ST_DX: begin
        dx_q <= pxc_q + pys_q;
        dy_q <= pyc_q - pxs_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = x_acc_q;
  assign pos_y_o     = y_acc_q;
  assign heading_o   = heading_q;

endmodule

@@ hdl/twodo_checker.sv @@
// twodo_checker: port-level checks for the three-wheel odometry block
// bound to tracking_wheel_odometry, no package dependency
module twodo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [47:0] pos_x_o,
  input logic signed [47:0] pos_y_o,
  input logic [31:0]        heading_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o)
                                    && $stable(pos_y_o) && $stable(heading_o))
    else $error("stalled result changed");

  // busy after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // a result never appears straight after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // heading moves only with a new result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(heading_o) |-> out_valid_o)
    else $error("heading changed without result");

endmodule

bind tracking_wheel_odometry twodo_checker u_twodo_checker (.*);

@@ tb/tb_odometry_checker.sv @@
// tb_odometry_checker: watches the count, result and register channels of
// tracking_wheel_odometry, predicts each pose update and compares it
// depends on twodo_pkg
module tb_odometry_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] left_count_i,
  input  logic signed [31:0] right_count_i,
  input  logic signed [31:0] back_count_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [47:0] pos_x_i,
  input  logic signed [47:0] pos_y_i,
  input  logic [31:0]        heading_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 poses_seen_o
);
  import twodo_pkg::*;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        heading;
  } pose_t;

  localparam longint ANGLE_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  pose_t       pose_q[$];
  logic [23:0] tick_dist, off_left, off_right, off_back;
  logic [31:0] prev_left, prev_right, prev_back, head;
  longint      pos_x, pos_y;

  function automatic longint mul_frac(longint a, longint k);
    longint unsigned ua, uk, r;
    ua = (a < 0) ? -a : a;
    uk = (k < 0) ? -k : k;
    r = (ua >> 30) * uk + (((ua & 64'h3FFF_FFFF) * uk) >> 30);
    return ((a < 0) != (k < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return v;
  endfunction

  function automatic pose_t advance_pose(logic [31:0] lc, logic [31:0] rc,
                                         logic [31:0] bc);
    longint ld, rd, bd, diff, turn, dhead, sx, sy, xl, yl, cx, cy, nx, z;
    longint dx, dy, gain;
    longint unsigned span, q, hm, u, p;
    logic [89:0] num;
    logic [31:0] a, mid;
    logic flip;
    pose_t r;
    ld = longint'($signed(lc - prev_left)) * longint'(tick_dist);
    rd = longint'($signed(rc - prev_right)) * longint'(tick_dist);
    bd = longint'($signed(bc - prev_back)) * longint'(tick_dist);
    prev_left = lc;
    prev_right = rc;
    prev_back = bc;
    diff = ld - rd;
    span = longint'(off_left) + longint'(off_right);
    turn = 0;
    if (span != 0 && diff != 0) begin
      num = 90'(longint'((diff < 0) ? -diff : diff)) << 24;
      num = num / 90'(span);
      q = (num > 90'(TURN_LIMIT)) ? 64'(TURN_LIMIT) : 64'(num);
      turn = (diff < 0) ? -longint'(q) : longint'(q);
    end
    q = ((turn < 0 ? -turn : turn) * 64'(RAD_TO_BAM)) >> 32;
    dhead = (turn < 0) ? -longint'(q) : longint'(q);
    head = head + 32'(dhead);
    mid = head - 32'(dhead / 2);
    hm = (turn / 2 < 0) ? -(turn / 2) : turn / 2;
    u = (hm * hm) >> 34;
    p = 64'(ONE_Q30);
    for (int n = 7; n >= 1; n--)
      p = 64'(ONE_Q30) - ((u * p) >> 30) / longint'((2 * n) * (2 * n + 1));
    gain = longint'(p);
    sx = bd + ((turn * longint'(off_back)) >>> 24);
    sy = rd + ((turn * longint'(off_right)) >>> 24);
    xl = mul_frac(sx, gain);
    yl = mul_frac(sy, gain);
    a = mid;
    flip = a[31] ^ a[30];
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    cx = CORDIC_START;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= ANGLE_STEP[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += ANGLE_STEP[i];
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    dx = mul_frac(xl, cx) + mul_frac(yl, cy);
    dy = mul_frac(yl, cx) - mul_frac(xl, cy);
    pos_x = clamp_pos(pos_x + (dx >>> 8));
    pos_y = clamp_pos(pos_y + (dy >>> 8));
    r.pos_x = pos_x[47:0];
    r.pos_y = pos_y[47:0];
    r.heading = head;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      tick_dist = TICK_RST;
      off_left = LEFT_RST;
      off_right = RIGHT_RST;
      off_back = BACK_RST;
      prev_left = '0;
      prev_right = '0;
      prev_back = '0;
      head = '0;
      pos_x = 0;
      pos_y = 0;
      pose_q.delete();
      fail_count_o = 0;
      poses_seen_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_addr_e'(paddr[3:2]))
          REG_TICK:  tick_dist = pwdata[23:0];
          REG_LEFT:  off_left = pwdata[23:0];
          REG_RIGHT: off_right = pwdata[23:0];
          REG_BACK:  off_back = pwdata[23:0];
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        poses_seen_o++;
        if (pose_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count_o++;
        end else begin
          e = pose_q.pop_front();
          if (pos_x_i !== e.pos_x) begin
            $error("pos_x expected %0d got %0d", e.pos_x, pos_x_i);
            fail_count_o++;
          end
          if (pos_y_i !== e.pos_y) begin
            $error("pos_y expected %0d got %0d", e.pos_y, pos_y_i);
            fail_count_o++;
          end
          if (heading_i !== e.heading) begin
            $error("heading expected %0h got %0h", e.heading, heading_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        pose_q.push_back(advance_pose(left_count_i, right_count_i, back_count_i));
    end
    pending_o = pose_q.size();
  end

endmodule

@@ tb/tb.sv @@
// tb: stimulus and verdict for tracking_wheel_odometry; encoder counts,
// register writes and result back-pressure, checked by tb_odometry_checker
// depends on twodo_pkg, tracking_wheel_odometry, tb_odometry_checker
module tb;
  import twodo_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] left_count_i = '0, right_count_i = '0, back_count_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [47:0] pos_x_o, pos_y_o;
  logic [31:0] heading_o;
  int fail_count, pending, poses_seen;
  int sent, reg_writes;
  bit no_idle;
  logic [31:0] cur_l, cur_r, cur_b;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  tracking_wheel_odometry dut (.*);

  tb_odometry_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .left_count_i, .right_count_i,
    .back_count_i, .out_valid_i(out_valid_o), .out_ready_i, .pos_x_i(pos_x_o),
    .pos_y_i(pos_y_o), .heading_i(heading_o), .fail_count_o(fail_count),
    .pending_o(pending), .poses_seen_o(poses_seen)
  );

  always @(negedge clk_i)
    out_ready_i <= no_idle || ($urandom_range(99) >= 30);

  task automatic reg_write(reg_addr_e idx, logic [23:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {8'($urandom_range(255)), val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    reg_writes++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic send(logic [31:0] l, logic [31:0] r, logic [31:0] b);
    if (!no_idle && $urandom_range(99) < 30) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 300)) @(negedge clk_i);
    end
    left_count_i = l;
    right_count_i = r;
    back_count_i = b;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    cur_l = l;
    cur_r = r;
    cur_b = b;
    sent++;
  endtask

  task automatic move_random(int n);
    int d;
    repeat (n) begin
      d = $urandom_range(99);
      if (d < 80)
        send(cur_l + 32'($signed($urandom_range(0, 400)) - 200),
             cur_r + 32'($signed($urandom_range(0, 400)) - 200),
             cur_b + 32'($signed($urandom_range(0, 400)) - 200));
      else if (d < 90)
        send(cur_l + 32'($signed($urandom_range(0, 8000)) - 4000), cur_r,
             cur_b + 32'($signed($urandom_range(0, 8000)) - 4000));
      else
        send($urandom, $urandom, $urandom);
    end
    in_valid_i = 1'b0;
  endtask

  initial begin
    no_idle = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send(32'd0, 32'd0, 32'd0);
    send(32'd90, 32'd90, 32'd0);
    send(32'd90, 32'd90, 32'd360);
    send(32'd200, 32'd90, 32'd360);
    send(32'd100, 32'd300, 32'd300);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    for (int i = 0; i < 6; i++)
      send(cur_l + 32'd2000, cur_r - 32'd2000, cur_b + 32'd50);
    in_valid_i = 1'b0;
    drain();
    reg_write(REG_TICK, 24'hFF_FFFF);
    reg_write(REG_LEFT, 24'd0);
    reg_write(REG_RIGHT, 24'd0);
    reg_write(REG_BACK, 24'hFF_FFFF);
    send(cur_l + 32'd100, cur_r - 32'd100, cur_b + 32'h7FFF_FFFF);
    send(cur_l, cur_r, cur_b + 32'h7FFF_FFFF);
    send(cur_l, cur_r, cur_b + 32'h7FFF_FFFF);
    send(cur_l, cur_r, cur_b + 32'h8000_0000);
    move_random(20);
    drain();
    reg_write(REG_LEFT, 24'd1);
    reg_write(REG_RIGHT, 24'hFF_FFFF);
    reg_write(REG_TICK, 24'd0);
    move_random(30);
    drain();
    reg_write(REG_TICK, TICK_RST);
    reg_write(REG_LEFT, LEFT_RST);
    reg_write(REG_RIGHT, LEFT_RST);
    reg_write(REG_BACK, 24'd0);
    move_random(100);
    no_idle = 1'b1;
    move_random(80);
    no_idle = 1'b0;
    drain();
    reg_write(REG_TICK, 24'(($urandom_range(1, 4000000))));
    reg_write(REG_LEFT, 24'($urandom));
    reg_write(REG_RIGHT, 24'($urandom));
    reg_write(REG_BACK, 24'($urandom));
    move_random(300);
    drain();
    reg_write(REG_TICK, 24'hFF_FFFF);
    reg_write(REG_LEFT, 24'hFF_FFFF);
    reg_write(REG_RIGHT, 24'd1);
    reg_write(REG_BACK, 24'd1);
    move_random(150);
    drain();
    $display("%0d count transactions, %0d pose results, %0d register writes",
             sent, poses_seen, reg_writes);
    $display("covered default, zero, extreme and random register settings");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(20 * 3_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
